### design/tpd_pkg.sv
// shared types, constants and row packing for the planar tile dedup engine
package tpd_pkg;

    // default store depth in tiles
    localparam int MAX_UNIQUE_TILES = 1024;

    // field widths
    localparam int ROW_W      = 16;
    localparam int PLANE_W    = 8;
    localparam int PAL_W      = 3;
    localparam int TILE_ID_W  = 10;
    localparam int ATTR_W     = 8;
    localparam int WORD_W     = 64;
    localparam int DEPTH_W    = 2;
    localparam int CAP_W      = 11;
    localparam int LIMIT_W    = CAP_W + 1;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // tile geometry
    localparam int          TILE_ROWS = 8;
    localparam logic [2:0]  LAST_ROW  = 3'd7;
    localparam int          ATTR_BANK_BIT = 3;

    // register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_BIT_DEPTH = 2'd0;
    localparam logic [1:0] REG_BANK0_CAP = 2'd1;
    localparam logic [1:0] REG_BANK1_CAP = 2'd2;

    // register reset values and the one-plane depth code
    localparam logic [DEPTH_W-1:0] BIT_DEPTH_RST = 2'd2;
    localparam logic [DEPTH_W-1:0] BIT_DEPTH_ONE = 2'd1;
    localparam logic [CAP_W-1:0]   BANK_CAP_RST  = 11'h100;

    // one row of pixels in
    typedef struct packed {
        logic [ROW_W-1:0] row_pixels;
        logic [PAL_W-1:0] palette_slot;
    } row_item_t;

    // one tile result out
    typedef struct packed {
        logic [TILE_ID_W-1:0] tile_id;
        logic                 is_new;
        logic [ATTR_W-1:0]    attr_byte;
        logic [WORD_W-1:0]    data_rows_low;
        logic [WORD_W-1:0]    data_rows_high;
        logic                 overflow;
    } tile_item_t;

    // split a row into its planes: high plane in 15:8, low plane in 7:0
    function automatic logic [ROW_W-1:0] pack_row(input logic [ROW_W-1:0] pixels);
        logic [PLANE_W-1:0] lo;
        logic [PLANE_W-1:0] hi;
        lo = '0;
        hi = '0;
        for (int x = 0; x < PLANE_W; x++)
        begin
            lo[PLANE_W-1-x] = pixels[ROW_W-2-2*x];
            hi[PLANE_W-1-x] = pixels[ROW_W-1-2*x];
        end
        return {hi, lo};
    endfunction

endpackage

### design/tpd_ram.sv
// generic single-write, single-read ram with registered read data
module tpd_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/tpd_row_cell.sv
// one cell of the row chain: holds the two plane bytes of one tile row
module tpd_row_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift,
    input  logic [tpd_pkg::ROW_W-1:0] planes_in,
    output logic [tpd_pkg::ROW_W-1:0] planes_out
);
    import tpd_pkg::*;

    logic [ROW_W-1:0] planes_reg;
    logic [ROW_W-1:0] planes_next;

    // take the neighbor's row when a row item comes in
    always_comb
    begin
        planes_next = shift ? planes_in : planes_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_reg <= '0;
        end
        else
        begin
            planes_reg <= planes_next;
        end
    end

    assign planes_out = planes_reg;

endmodule

### design/tile_planar_dedup_engine.sv
// top level: row chain, tile store search and result register
//
//   channel   | dir | handshake              | payload
//   ----------+-----+------------------------+---------------------------
//   row       | in  | row_valid / row_ready   | row_item (tpd_pkg::row_item_t)
//   tile      | out | tile_valid / tile_ready | tile_result (tpd_pkg::tile_item_t)
//   apb       | in  | psel/penable/pready     | paddr, pwdata, prdata
//
// rows 1..7 of a tile give no result; rows are taken only in the idle state.
// the eighth row starts a scan of the tile store, one stored tile per cycle
// through the store ram read port; a match, or the end of the stored tiles
// with no match, ends the scan, and the emit state then loads the result.
// reset clears control state, config registers and row chain; the store needs no clearing pass.
// a finished result waits in the output register; rows of the next tile are
// taken meanwhile, and a new result waits until the register is free.
module tile_planar_dedup_engine #(
    parameter int MAX_TILES = tpd_pkg::MAX_UNIQUE_TILES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // row items
    input  logic                          row_valid,
    output logic                          row_ready,
    input  tpd_pkg::row_item_t            row_item,
    // tile results
    output logic                          tile_valid,
    input  logic                          tile_ready,
    output tpd_pkg::tile_item_t           tile_result,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpd_pkg::APB_AW-1:0]    paddr,
    input  logic [tpd_pkg::APB_DW-1:0]    pwdata,
    output logic [tpd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import tpd_pkg::*;

    localparam int CW = $clog2(MAX_TILES + 1);
    localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int SW = 2 * WORD_W;
    localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(MAX_TILES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    // configuration registers
    logic [DEPTH_W-1:0] bit_depth_reg;
    logic [CAP_W-1:0]   bank0_cap_reg;
    logic [CAP_W-1:0]   bank1_cap_reg;
    logic               cfg_wr;

    // control state
    state_t        state_reg, state_next;
    logic [2:0]    row_count_reg, row_count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic [CW-1:0] unique_count_reg, unique_count_next;
    logic          tile_valid_reg, tile_valid_next;

    // payload state
    logic [CW-1:0]    pend_addr_reg;
    logic [CW-1:0]    found_id_reg;
    logic             mode_two_reg;
    logic [PAL_W-1:0] pal_reg;
    tile_item_t       tile_result_reg, tile_result_next;

    // datapath
    logic                row_acc;
    logic                last_row;
    logic                match;
    logic                issue;
    logic                emit;
    logic                store_new;
    logic [ROW_W-1:0]    cell_in  [TILE_ROWS];
    logic [ROW_W-1:0]    cell_out [TILE_ROWS];
    logic [WORD_W-1:0]   w0, w1;
    logic [WORD_W-1:0]   two_w0, two_w1, one_w0;
    logic [SW-1:0]       rd_data;
    logic [LIMIT_W-1:0]  cap_sum, limit;
    logic                no_room;
    logic [LIMIT_W-1:0]  res_id;
    logic                bank;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= BIT_DEPTH_RST;
            bank0_cap_reg <= BANK_CAP_RST;
            bank1_cap_reg <= BANK_CAP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_BIT_DEPTH: bit_depth_reg <= pwdata[DEPTH_W-1:0];
                REG_BANK0_CAP: bank0_cap_reg <= pwdata[CAP_W-1:0];
                REG_BANK1_CAP: bank1_cap_reg <= pwdata[CAP_W-1:0];
                default:       ;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (paddr[3:2])
            REG_BIT_DEPTH: prdata = APB_DW'(bit_depth_reg);
            REG_BANK0_CAP: prdata = APB_DW'(bank0_cap_reg);
            REG_BANK1_CAP: prdata = APB_DW'(bank1_cap_reg);
            default:       prdata = '0;
        endcase
    end

    // row chain: newest row in cell 0, row y ends up in cell 7-y
    assign row_ready = (state_reg == S_IDLE);
    assign row_acc   = row_valid && row_ready;
    assign last_row  = (row_count_reg == LAST_ROW);

    generate
        for (genvar k = 0; k < TILE_ROWS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign cell_in[k] = pack_row(row_item.row_pixels);
            end
            else
            begin : g_link
                assign cell_in[k] = cell_out[k-1];
            end

            tpd_row_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (row_acc),
                .planes_in  (cell_in[k]),
                .planes_out (cell_out[k])
            );
        end
    endgenerate

    // assemble tile words from the chain
    always_comb
    begin
        two_w0 = '0;
        two_w1 = '0;
        one_w0 = '0;
        for (int y = 0; y < TILE_ROWS; y++)
        begin
            one_w0[PLANE_W*y +: PLANE_W] = cell_out[TILE_ROWS-1-y][PLANE_W-1:0];
            if (y < TILE_ROWS / 2)
            begin
                two_w0[ROW_W*y +: ROW_W] = cell_out[TILE_ROWS-1-y];
            end
            else
            begin
                two_w1[ROW_W*(y-TILE_ROWS/2) +: ROW_W] = cell_out[TILE_ROWS-1-y];
            end
        end
        w0 = mode_two_reg ? two_w0 : one_w0;
        w1 = mode_two_reg ? two_w1 : '0;
    end

    // tile store
    assign store_new = emit && !found_reg && !no_room;

    tpd_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_TILES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_new),
        .wr_addr (unique_count_reg[AW-1:0]),
        .wr_data ({w1, w0}),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // compare the stored tile read last cycle
    assign match = pend_reg && (rd_data[WORD_W-1:0] == w0)
                   && (!mode_two_reg || (rd_data[SW-1:WORD_W] == w1));

    // store limit and attribute bank bit
    assign cap_sum = LIMIT_W'(bank0_cap_reg) + LIMIT_W'(bank1_cap_reg);
    assign limit   = (cap_sum > MAX_LIMIT) ? MAX_LIMIT : cap_sum;
    assign no_room = (LIMIT_W'(unique_count_reg) >= limit);
    assign res_id  = found_reg ? LIMIT_W'(found_id_reg) : LIMIT_W'(unique_count_reg);
    assign bank    = (res_id >= LIMIT_W'(bank0_cap_reg));

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        row_count_next    = row_count_reg;
        scan_idx_next     = scan_idx_reg;
        pend_next         = 1'b0;
        found_next        = found_reg;
        unique_count_next = unique_count_reg;
        issue             = 1'b0;
        emit              = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (row_acc)
                begin
                    if (last_row)
                    begin
                        row_count_next = '0;
                        scan_idx_next  = '0;
                        found_next     = 1'b0;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        row_count_next = row_count_reg + 3'd1;
                    end
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    state_next = S_EMIT;
                end
                else if (scan_idx_reg >= unique_count_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    issue         = 1'b1;
                    pend_next     = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end
            S_EMIT:
            begin
                if (!tile_valid_reg || tile_ready)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (!found_reg && !no_room)
                    begin
                        unique_count_next = unique_count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result build
    always_comb
    begin
        tile_result_next                = '0;
        tile_result_next.attr_byte      = ATTR_W'(pal_reg);
        if (found_reg)
        begin
            tile_result_next.tile_id = TILE_ID_W'(found_id_reg);
            tile_result_next.attr_byte[ATTR_BANK_BIT] = bank;
        end
        else if (no_room)
        begin
            tile_result_next.overflow = 1'b1;
        end
        else
        begin
            tile_result_next.tile_id        = TILE_ID_W'(unique_count_reg);
            tile_result_next.is_new         = 1'b1;
            tile_result_next.attr_byte[ATTR_BANK_BIT] = bank;
            tile_result_next.data_rows_low  = w0;
            tile_result_next.data_rows_high = w1;
        end
    end

    // output valid
    always_comb
    begin
        if (emit)
        begin
            tile_valid_next = 1'b1;
        end
        else if (tile_ready)
        begin
            tile_valid_next = 1'b0;
        end
        else
        begin
            tile_valid_next = tile_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_count_reg    <= '0;
            scan_idx_reg     <= '0;
            pend_reg         <= 1'b0;
            found_reg        <= 1'b0;
            unique_count_reg <= '0;
            tile_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            scan_idx_reg     <= scan_idx_next;
            pend_reg         <= pend_next;
            found_reg        <= found_next;
            unique_count_reg <= unique_count_next;
            tile_valid_reg   <= tile_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (row_acc && last_row)
        begin
            mode_two_reg <= (bit_depth_reg != BIT_DEPTH_ONE);
            pal_reg      <= row_item.palette_slot;
        end
        if (issue)
        begin
            pend_addr_reg <= scan_idx_reg;
        end
        if (match && (state_reg == S_SCAN))
        begin
            found_id_reg <= pend_addr_reg;
        end
        if (emit)
        begin
            tile_result_reg <= tile_result_next;
        end
    end

    assign tile_valid  = tile_valid_reg;
    assign tile_result = tile_result_reg;

    // checks
    a_last_row_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (row_acc && last_row) |=> (state_reg == S_SCAN))
        else $error("eighth row did not start a scan");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (LIMIT_W'(unique_count_reg) <= MAX_LIMIT))
        else $error("unique count beyond store depth");

    a_count_moves_with_new: assert property (@(posedge clk) disable iff (!rst_n)
        (unique_count_reg != $past(unique_count_reg)) |-> (tile_valid_reg && tile_result_reg.is_new))
        else $error("unique count changed without a new tile result");

    a_rows_idle_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (row_count_reg == '0))
        else $error("row count not cleared during search");

    a_new_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        tile_valid_reg |-> !(tile_result_reg.is_new && tile_result_reg.overflow))
        else $error("result marked both new and overflow");

endmodule
